// ----- design/sphkd_pkg.sv -----
// ----------------------------------------------------------------------------
// SPH kernel density package
// Shared fixed-point constants, configuration indexes and transfer types.
// ----------------------------------------------------------------------------
package sphkd_pkg;

    localparam int FRAC = 16;
    localparam logic [31:0] ONE_Q = 32'(1) << FRAC;
    localparam logic [31:0] TWO_Q = 32'(2) << FRAC;

    localparam logic [2:0] CFG_INV_H   = 3'd0;
    localparam logic [2:0] CFG_ALPHA   = 3'd1;
    localparam logic [2:0] CFG_MASS    = 3'd2;
    localparam logic [2:0] CFG_REST    = 3'd3;
    localparam logic [2:0] CFG_CLAMP   = 3'd4;

    localparam int DVD_W = 59;
    localparam int DVS_W = 24;
    localparam int QUO_W = 32;

    typedef struct packed {
        logic [15:0]        neighbor_index;
        logic [23:0]        distance;
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic signed [23:0] offset_z;
        logic               self_boundary;
        logic               last_neighbor;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        neighbor_id_out;
        logic [31:0]        kernel_value;
        logic signed [31:0] gradient_x;
        logic signed [31:0] gradient_y;
        logic signed [31:0] gradient_z;
        logic               density_valid;
        logic [31:0]        density_out;
    } t_out_item;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

// ----- design/sph_kernel_density.sv -----
// ----------------------------------------------------------------------------
// SPH cubic-spline kernel and density accumulator
// Kernel weight, gradient and running density for one neighbour per transfer.
// ----------------------------------------------------------------------------
//  channel   valid     stall     payload
//  input     i_valid   o_stall   i_in  (t_in_item)
//  output    o_valid   i_stall   o_out (t_out_item)
//  config    i_cfg_we  -         i_cfg_idx, i_cfg_data
//
// Each item makes eight passes through the shared 32x32 multiplier; unless the
// distance is zero, each gradient component then takes two multiplier passes
// and a run of the serial divider, which stops early when the quotient would
// not fit in 32 bits.
// Reset clears the configuration to its defaults and the density sum to zero.
// A new item is taken only when the sequencer is idle; a finished result waits
// in the output register while the next item is already being worked on.
module sph_kernel_density (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sphkd_pkg::t_in_item   i_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sphkd_pkg::t_out_item  o_out,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data
);
    import sphkd_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIN} t_state;
    typedef enum logic [3:0] {
        OP_Q, OP_T1SQ, OP_T2SQ, OP_T1CU, OP_T2CU, OP_KERN, OP_COEF, OP_TERM,
        OP_GLO, OP_GHI
    } t_op;

    t_state            r_state;
    t_op               r_op;
    logic [1:0]        r_comp;
    t_in_item          r_in;
    logic [23:0]       r_inv_h;
    logic [31:0]       r_alpha;
    logic [31:0]       r_mass;
    logic [31:0]       r_rest;
    logic              r_clamp;
    logic [47:0]       r_sum;
    logic [31:0]       r_q;
    logic [16:0]       r_t1sq;
    logic [18:0]       r_t2sq;
    logic [16:0]       r_t1cu;
    logic [19:0]       r_t2cu;
    logic [31:0]       r_kern;
    logic [35:0]       r_coef;
    logic              r_sneg;
    logic [DVD_W-1:0]  r_num;
    logic              r_div_go;
    logic [31:0]       r_grad [3];
    t_out_item         r_out;
    logic              r_out_valid;

    logic [16:0]  t1;
    logic [17:0]  t2;
    logic [19:0]  poly;
    logic [20:0]  gpos;
    logic [20:0]  gneg;
    logic [20:0]  smag;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  prod;
    logic [48:0]  sum49;
    logic [23:0]  off;
    logic         off_neg;
    logic [23:0]  mag;
    t_div_stat    div_stat;
    logic [31:0]  quo;
    logic         qbig;
    logic         rneg;
    logic [31:0]  gval;
    logic [31:0]  dens;
    logic [31:0]  dsat;
    logic         fin_go;

    assign t1   = (r_q < ONE_Q) ? 17'(ONE_Q - r_q) : '0;
    assign t2   = (r_q < TWO_Q) ? 18'(TWO_Q - r_q) : '0;
    assign poly = ({r_t2cu} > {1'b0, r_t1cu, 2'b00}) ?
                  20'(r_t2cu - {1'b0, r_t1cu, 2'b00}) : '0;
    assign gpos = 21'({r_t1sq, 3'b000}) + 21'({r_t1sq, 2'b00});
    assign gneg = 21'({r_t2sq, 1'b0}) + 21'(r_t2sq);
    assign smag = (gneg > gpos) ? gneg - gpos : gpos - gneg;

    always_comb begin
        case (r_comp)
            2'd0:    off = r_in.offset_x;
            2'd1:    off = r_in.offset_y;
            default: off = r_in.offset_z;
        endcase
    end
    assign off_neg = off[23];
    assign mag     = off_neg ? 24'(-off) : off;

    always_comb begin
        case (r_op)
            OP_Q:    begin mul_a = {8'd0, r_in.distance}; mul_b = {8'd0, r_inv_h}; end
            OP_T1SQ: begin mul_a = 32'(t1);               mul_b = 32'(t1);         end
            OP_T2SQ: begin mul_a = 32'(t2);               mul_b = 32'(t2);         end
            OP_T1CU: begin mul_a = 32'(r_t1sq);           mul_b = 32'(t1);         end
            OP_T2CU: begin mul_a = 32'(r_t2sq);           mul_b = 32'(t2);         end
            OP_KERN: begin mul_a = r_alpha;               mul_b = 32'(poly);       end
            OP_COEF: begin mul_a = r_alpha;               mul_b = 32'(smag);       end
            OP_TERM: begin mul_a = r_mass;                mul_b = r_kern;          end
            OP_GLO:  begin mul_a = r_coef[31:0];          mul_b = 32'(mag);        end
            OP_GHI:  begin mul_a = 32'(r_coef[35:32]);    mul_b = 32'(mag);        end
            default: begin mul_a = '0;                    mul_b = '0;              end
        endcase
    end
    assign prod  = mul_a * mul_b;
    assign sum49 = {1'b0, r_sum} + {1'b0, prod[FRAC+:48]};

    sphkd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_num),
        .i_divisor  (r_in.distance),
        .o_stat     (div_stat),
        .o_quotient (quo)
    );

    assign qbig = div_stat.ovf;
    assign rneg = (off_neg != r_sneg) && (qbig || quo != '0);
    always_comb begin
        if (rneg) begin
            gval = (qbig || quo > 32'h8000_0000) ? 32'h8000_0000 : 32'(-quo);
        end else begin
            gval = (qbig || quo[31]) ? 32'h7FFF_FFFF : quo;
        end
    end

    assign dsat = (r_sum[47:32] != '0) ? 32'hFFFF_FFFF : r_sum[31:0];
    always_comb begin
        if (r_in.self_boundary) begin
            dens = r_rest;
        end else if (r_clamp && dsat < r_rest) begin
            dens = r_rest;
        end else begin
            dens = dsat;
        end
    end

    assign fin_go = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_Q;
            r_comp      <= '0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_inv_h     <= 24'd65536;
            r_alpha     <= 32'd5215;
            r_mass      <= 32'd65536;
            r_rest      <= 32'd65536000;
            r_clamp     <= 1'b0;
        end else begin
            r_div_go <= (r_state == S_MUL) && (r_op == OP_GHI);
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INV_H: r_inv_h <= i_cfg_data[23:0];
                    CFG_ALPHA: r_alpha <= i_cfg_data;
                    CFG_MASS:  r_mass  <= i_cfg_data;
                    CFG_REST:  r_rest  <= i_cfg_data;
                    CFG_CLAMP: r_clamp <= i_cfg_data[0];
                    default:   ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in      <= i_in;
                        r_op      <= OP_Q;
                        r_comp    <= '0;
                        r_grad[0] <= '0;
                        r_grad[1] <= '0;
                        r_grad[2] <= '0;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_op)
                        OP_Q:    begin r_q    <= prod[FRAC+:32]; r_op <= OP_T1SQ; end
                        OP_T1SQ: begin r_t1sq <= prod[FRAC+:17]; r_op <= OP_T2SQ; end
                        OP_T2SQ: begin r_t2sq <= prod[FRAC+:19]; r_op <= OP_T1CU; end
                        OP_T1CU: begin r_t1cu <= prod[FRAC+:17]; r_op <= OP_T2CU; end
                        OP_T2CU: begin r_t2cu <= prod[FRAC+:20]; r_op <= OP_KERN; end
                        OP_KERN: begin
                            r_kern <= (prod[FRAC+32+:4] != '0) ? 32'hFFFF_FFFF
                                                               : prod[FRAC+:32];
                            r_op   <= OP_COEF;
                        end
                        OP_COEF: begin
                            r_coef <= prod[FRAC+:36];
                            r_sneg <= gneg > gpos;
                            r_op   <= OP_TERM;
                        end
                        OP_TERM: begin
                            r_sum <= sum49[48] ? '1 : sum49[47:0];
                            if (r_in.distance == '0) begin
                                r_state <= S_FIN;
                            end else begin
                                r_op <= OP_GLO;
                            end
                        end
                        OP_GLO: begin
                            r_num <= prod[DVD_W-1:0];
                            r_op  <= OP_GHI;
                        end
                        OP_GHI: begin
                            r_num    <= r_num + {prod[DVD_W-33:0], 32'd0};
                            r_state  <= S_DIV;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_grad[r_comp] <= gval;
                        if (r_comp == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_op    <= OP_GLO;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_out.neighbor_id_out <= r_in.neighbor_index;
                        r_out.kernel_value    <= r_kern;
                        r_out.gradient_x      <= r_grad[0];
                        r_out.gradient_y      <= r_grad[1];
                        r_out.gradient_z      <= r_grad[2];
                        r_out.density_valid   <= r_in.last_neighbor;
                        r_out.density_out     <= r_in.last_neighbor ? dens : '0;
                        if (r_in.last_neighbor) begin
                            r_sum <= '0;
                        end
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// ----- design/sphkd_div.sv -----
// ----------------------------------------------------------------------------
// SPH kernel density serial divider
// Restoring divider, one quotient bit per cycle, flags quotients of 2^32 or more.
// ----------------------------------------------------------------------------
module sphkd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sphkd_pkg::DVD_W-1:0]    i_dividend,
    input  logic [sphkd_pkg::DVS_W-1:0]    i_divisor,
    output sphkd_pkg::t_div_stat           o_stat,
    output logic [sphkd_pkg::QUO_W-1:0]    o_quotient
);
    import sphkd_pkg::*;

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic              r_done;
    logic              r_ovf;
    logic [DVS_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    sh;
    logic              fits;
    logic              big;

    assign sh   = {r_rem, r_quo[QUO_W-1]};
    assign fits = sh >= {1'b0, r_dvs};
    assign big  = i_dividend[DVD_W-1:QUO_W] >= {3'b000, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= i_start ? big : (r_busy && r_cnt == 5'd31);
            if (i_start) begin
                r_dvs <= i_divisor;
                r_quo <= i_dividend[QUO_W-1:0];
                r_rem <= i_dividend[DVS_W+QUO_W-1:QUO_W];
                r_cnt <= '0;
                r_ovf <= big;
                r_busy <= !big;
            end else if (r_busy) begin
                r_rem <= fits ? DVS_W'(sh - {1'b0, r_dvs}) : sh[DVS_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], fits};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_quotient  = r_quo;

endmodule
